// ===== design/wsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Websocket deframer package
// Shared types, codes and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int LEN_W     = 32;
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
	localparam logic [7:0] HDR_RSV_BITS = 8'h70;
	localparam logic [7:0] HDR_OP_BITS  = 8'h0f;
	localparam logic [7:0] HDR_MASK_BIT = 8'h80;
	localparam logic [7:0] HDR_LEN_BITS = 8'h7f;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_STOP    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_BYTE    = 3'd0,
		K_END     = 3'd1,
		K_DISCARD = 3'd2,
		K_PONG    = 3'd3,
		K_CLOSE   = 3'd4,
		K_ERROR   = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       msg_end;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} wr_t;

	function automatic logic is_data_op(input logic [3:0] op);
		is_data_op = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN);
	endfunction

endpackage
`default_nettype wire

// ===== design/wsd_res_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and hands out
// one result per request on the output channel.
// ----------------------------------------------------------------------------
module wsd_res_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wsd_pkg::wr_t       wr,
	output logic               room,
	output logic               res_valid,
	input  wire logic          res_stall,
	output wsd_pkg::res_t      res
);
	import wsd_pkg::*;

	res_t                 mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wp_q;
	logic [RES_PTR_W-1:0] rp_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign res_valid = (cnt_q != '0);
	assign res       = mem_q[rp_q];
	assign pop       = res_valid && !res_stall;
	assign room      = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) begin
			mem_q[wp_q] <= wr.r0;
		end
		if (wr.n == 2'd2) begin
			mem_q[wp_q + RES_PTR_W'(1)] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + RES_PTR_W'(wr.n);
			rp_q  <= rp_q + RES_PTR_W'(pop);
			cnt_q <= cnt_q + RES_CNT_W'(wr.n) - RES_CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== design/wsd_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser
// Header state machine, length and mask key capture, payload unmasking and
// result generation for one received byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] rx,
	output wsd_pkg::wr_t    wr
);
	import wsd_pkg::*;

	phase_t           ph_q, ph_d;
	logic [3:0]       op_q, op_d;
	logic             fin_q, fin_d;
	logic             msk_q, msk_d;
	logic [2:0]       hbc_q, hbc_d;
	logic [LEN_W-1:0] rem_q, rem_d;
	logic [3:0][7:0]  key_q, key_d;
	logic [1:0]       mpos_q, mpos_d;
	logic             frag_q, frag_d;

	logic [6:0]       len7;
	logic [LEN_W-1:0] rem_shift;
	logic [LEN_W-1:0] rem_dec;
	logic [LEN_W-1:0] rem_start;
	logic             start_now;
	logic             discard;
	logic             end_now;
	logic             pay_last;
	logic             data_op;
	logic             rsv_err;
	phase_t           end_phase;
	phase_t           start_phase;
	logic [7:0]       key_byte;
	res_t             cand [4];
	logic [3:0]       cand_v;

	assign len7      = rx[6:0] & HDR_LEN_BITS[6:0];
	assign rem_shift = {rem_q[LEN_W-9:0], rx};
	assign rem_dec   = rem_q - LEN_W'(1);
	assign data_op   = is_data_op(op_q);
	assign rsv_err   = (rx & HDR_RSV_BITS) != 8'h00;
	assign key_byte  = msk_q ? key_q[2'd3 - mpos_q] : 8'h00;
	assign end_phase = (op_q == OP_CLOSE) ? PH_STOP : PH_HDR0;

	always_comb begin
		start_now = 1'b0;
		rem_start = rem_q;
		pay_last  = 1'b0;
		unique case (ph_q)
			PH_HDR1: begin
				start_now = (len7 != LEN_EXT16) && (len7 != LEN_EXT64)
					&& ((rx & HDR_MASK_BIT) == 8'h00);
				rem_start = LEN_W'(len7);
			end
			PH_EXTLEN: begin
				start_now = (hbc_q == 3'd0) && !msk_q;
				rem_start = rem_shift;
			end
			PH_MASK: begin
				start_now = (hbc_q == 3'd0);
			end
			PH_PAYLOAD: begin
				pay_last = (rem_dec == '0);
			end
			default: begin
			end
		endcase
	end

	assign discard     = start_now && ((op_q == OP_TEXT) || (op_q == OP_BIN)) && frag_q;
	assign end_now     = (start_now && (rem_start == '0)) || pay_last;
	assign start_phase = (rem_start == '0) ? end_phase : PH_PAYLOAD;

	// Next-state logic.
	always_comb begin
		ph_d   = ph_q;
		op_d   = op_q;
		fin_d  = fin_q;
		msk_d  = msk_q;
		hbc_d  = hbc_q;
		rem_d  = rem_q;
		key_d  = key_q;
		mpos_d = mpos_q;
		frag_d = frag_q;
		unique case (ph_q)
			PH_HDR0: begin
				if (rsv_err) begin
					ph_d = PH_STOP;
				end else begin
					op_d  = rx[3:0] & HDR_OP_BITS[3:0];
					fin_d = (rx & HDR_FIN_BIT) != 8'h00;
					ph_d  = PH_HDR1;
				end
			end
			PH_HDR1: begin
				msk_d = (rx & HDR_MASK_BIT) != 8'h00;
				key_d = '0;
				if (len7 == LEN_EXT16) begin
					rem_d = '0;
					hbc_d = 3'd1;
					ph_d  = PH_EXTLEN;
				end else if (len7 == LEN_EXT64) begin
					rem_d = '0;
					hbc_d = 3'd7;
					ph_d  = PH_EXTLEN;
				end else begin
					rem_d = rem_start;
					if (msk_d) begin
						hbc_d = 3'd3;
						ph_d  = PH_MASK;
					end else begin
						ph_d = start_phase;
					end
				end
			end
			PH_EXTLEN: begin
				rem_d = rem_shift;
				if (hbc_q != 3'd0) begin
					hbc_d = hbc_q - 3'd1;
				end else if (msk_q) begin
					hbc_d = 3'd3;
					ph_d  = PH_MASK;
				end else begin
					ph_d = start_phase;
				end
			end
			PH_MASK: begin
				key_d = {key_q[2:0], rx};
				if (hbc_q != 3'd0) begin
					hbc_d = hbc_q - 3'd1;
				end else begin
					ph_d = start_phase;
				end
			end
			PH_PAYLOAD: begin
				mpos_d = mpos_q + 2'd1;
				rem_d  = rem_dec;
				if (pay_last) begin
					ph_d = end_phase;
				end
			end
			default: begin
			end
		endcase
		if (start_now) begin
			mpos_d = 2'd0;
		end
		if (discard) begin
			frag_d = 1'b0;
		end
		if (end_now && data_op) begin
			frag_d = !fin_q;
		end
	end

	// Result generation, in the order the results are delivered.
	always_comb begin
		cand[0]   = '{kind: K_ERROR, data: 8'h00, msg_end: 1'b0, last: 1'b0};
		cand[1]   = '{kind: K_DISCARD, data: 8'h00, msg_end: 1'b0, last: 1'b0};
		cand[2]   = '{kind: K_BYTE, data: rx ^ key_byte, msg_end: pay_last && fin_q,
			last: 1'b0};
		cand[3]   = '{kind: K_END, data: 8'h00, msg_end: 1'b1, last: 1'b0};
		cand_v[0] = (ph_q == PH_HDR0) && rsv_err;
		cand_v[1] = discard;
		cand_v[2] = (ph_q == PH_PAYLOAD) && data_op;
		cand_v[3] = 1'b0;
		if (end_now) begin
			if (data_op) begin
				cand_v[3] = fin_q && !pay_last;
			end else if (op_q == OP_PING) begin
				cand[3]   = '{kind: K_PONG, data: 8'h00, msg_end: 1'b0, last: 1'b0};
				cand_v[3] = 1'b1;
			end else if (op_q == OP_CLOSE) begin
				cand[3]   = '{kind: K_CLOSE, data: 8'h00, msg_end: 1'b0, last: 1'b0};
				cand_v[3] = 1'b1;
			end
		end
	end

	always_comb begin
		wr.n  = 2'd0;
		wr.r0 = cand[0];
		wr.r1 = cand[0];
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				if (wr.n == 2'd0) begin
					wr.r0 = cand[i];
				end else begin
					wr.r1 = cand[i];
				end
				wr.n = wr.n + 2'd1;
			end
		end
		if (wr.n == 2'd1) begin
			wr.r0.last = 1'b1;
		end
		if (wr.n == 2'd2) begin
			wr.r1.last = 1'b1;
		end
		if (!fire) begin
			wr.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_HDR0;
			op_q   <= '0;
			fin_q  <= 1'b0;
			msk_q  <= 1'b0;
			hbc_q  <= '0;
			rem_q  <= '0;
			key_q  <= '0;
			mpos_q <= '0;
			frag_q <= 1'b0;
		end else if (fire) begin
			ph_q   <= ph_d;
			op_q   <= op_d;
			fin_q  <= fin_d;
			msk_q  <= msk_d;
			hbc_q  <= hbc_d;
			rem_q  <= rem_d;
			key_q  <= key_d;
			mpos_q <= mpos_d;
			frag_q <= frag_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/websocket_frame_deframer.sv =====
`default_nettype none
// An accepted byte is registered in byte_s1, and its results are then written into the result queue.
// Throughput: one byte per cycle while the result queue has room for two results.
// Each byte gives zero, one or two results; the output drains one result per cycle while res_stall is low.
// Reset clears the parser state and the result queue; the first byte after reset
// is taken as the first header byte of a frame.
// ----------------------------------------------------------------------------
// Websocket frame deframer
// Parses received websocket frame headers, unmasks data payload bytes and
// reports message ends, discards, pong and close requests and header errors.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [2:0]      kind,
	output logic [7:0]      data,
	output logic            message_end,
	output logic            last_of_run
);
	import wsd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       room;
	logic       fire;
	wr_t        wr;
	res_t       res;

	assign fire     = valid_s1 && room;
	assign rx_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.rx     (byte_s1),
		.wr     (wr)
	);

	wsd_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign kind        = res.kind;
	assign data        = res.data;
	assign message_end = res.msg_end;
	assign last_of_run = res.last;

endmodule
`default_nettype wire
